### src/smsd_pkg.sv
// ----------------------------------------------------------------------------
// smsd_pkg
// Shared types and constants of the spin motion and sleep detector.
// ----------------------------------------------------------------------------
package smsd_pkg;

  // Fixed-point coefficients, Q1.15
  localparam int COEF_TORQUE = 287;    // 0.008748
  localparam int COEF_NEW    = 31130;  // 0.95
  localparam int COEF_OLD    = 1638;   // 0.05
  localparam int ROUND_Q15   = 16384;

  // Rate-of-change scale and sleep jump
  localparam int USEC_SCALE = 1000000;
  localparam int SLEEP_JUMP = 10;

  // Quotient bits of the rate-of-change divide (|d| * 1e6 < 2^35)
  localparam int DIV_BITS = 35;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_AIRBORNE   = 2'd0;
  localparam logic [1:0] REG_SLEEP      = 2'd1;
  localparam logic [1:0] REG_STAT_RESET = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_ACCEL,
    ST_SCALE,
    ST_MNEW,
    ST_MOLD,
    ST_FIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic accel_ld;
    logic scale;
    logic mnew;
    logic mold;
    logic fin;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic dt_zero;
    logic div_done;
    logic out_free;
  } stat_t;

  // Configuration thresholds
  typedef struct packed {
    logic [15:0] airborne_threshold;
    logic [15:0] sleep_threshold;
    logic [15:0] stationary_reset;
  } cfg_t;

endpackage

### src/spin_motion_sleep_detector.sv
// ----------------------------------------------------------------------------
// spin_motion_sleep_detector
// Gyro torque estimate with motion and sleep detection.
// ----------------------------------------------------------------------------
// One sample (rate_sample, time_us) is taken at a time and yields one result
// word. A sample with a nonzero time delta passes through the accept step, a
// setup step, the bit-serial restoring divider that forms |d| * 1e6 / dt (one
// quotient bit per cycle), then saturation, the torque scale, the two filter
// products and the commit. A sample with a zero time delta skips the divider
// and the saturation step. The result sits in an output register, so the
// block takes the next sample while the previous word still waits; it holds
// only when a new result is ready and the old one has not yet been taken.
// Thresholds are written through the APB-style port; the user must write them
// only while no sample is in flight; the block itself does not enforce it.
module spin_motion_sleep_detector import smsd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // Sample input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] rate_sample,
  input  logic [31:0]        time_us,
  // Result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] torque_est,
  output logic               is_moving,
  output logic               sleep_active,
  output logic               motion_mode,
  output logic [15:0]        still_count,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cmd_t  cmd;
  stat_t stat;
  cfg_t  cfg;

  smsd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  smsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  smsd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg          (cfg),
    .rate_sample  (rate_sample),
    .time_us      (time_us),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .torque_est   (torque_est),
    .is_moving    (is_moving),
    .sleep_active (sleep_active),
    .motion_mode  (motion_mode),
    .still_count  (still_count)
  );

endmodule

### src/smsd_regs.sv
// ----------------------------------------------------------------------------
// smsd_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module smsd_regs import smsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Write thresholds
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.airborne_threshold <= 16'd3200;
      cfg.sleep_threshold    <= 16'd100;
      cfg.stationary_reset   <= 16'd1000;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_AIRBORNE:   cfg.airborne_threshold <= pwdata[15:0];
        REG_SLEEP:      cfg.sleep_threshold    <= pwdata[15:0];
        REG_STAT_RESET: cfg.stationary_reset   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[3:2])
      REG_AIRBORNE:   prdata = {16'd0, cfg.airborne_threshold};
      REG_SLEEP:      prdata = {16'd0, cfg.sleep_threshold};
      REG_STAT_RESET: prdata = {16'd0, cfg.stationary_reset};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

### src/smsd_ctrl.sv
// ----------------------------------------------------------------------------
// smsd_ctrl
// Sequencer that steps one sample through the datapath.
// ----------------------------------------------------------------------------
module smsd_ctrl import smsd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_PREP;
      ST_PREP:  state_next = stat.dt_zero ? ST_SCALE : ST_DIV;
      ST_DIV:   if (stat.div_done) state_next = ST_ACCEL;
      ST_ACCEL: state_next = ST_SCALE;
      ST_SCALE: state_next = ST_MNEW;
      ST_MNEW:  state_next = ST_MOLD;
      ST_MOLD:  state_next = ST_FIN;
      ST_FIN:   if (stat.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE:  cmd.load     = in_valid;
      ST_PREP:  cmd.prep     = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_ACCEL: cmd.accel_ld = 1'b1;
      ST_SCALE: cmd.scale    = 1'b1;
      ST_MNEW:  cmd.mnew     = 1'b1;
      ST_MOLD:  cmd.mold     = 1'b1;
      ST_FIN:   cmd.fin      = stat.out_free;
      default: ;
    endcase
  end

  // A zero time delta never enters the divider
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> !stat.dt_zero)
    else $error("divider running with zero time delta");

  // Hold the final step while the output word is still waiting
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && !stat.out_free |=> state == ST_FIN)
    else $error("final step left with output slot busy");

endmodule

### src/smsd_dp.sv
// ----------------------------------------------------------------------------
// smsd_dp
// Datapath: rate change, bit-serial divide, torque filter, stillness counter.
// ----------------------------------------------------------------------------
module smsd_dp import smsd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  cfg_t               cfg,
  input  logic signed [15:0] rate_sample,
  input  logic [31:0]        time_us,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] torque_est,
  output logic               is_moving,
  output logic               sleep_active,
  output logic               motion_mode,
  output logic [15:0]        still_count
);

  localparam logic signed [40:0] K_TORQUE = 41'(COEF_TORQUE);
  localparam logic signed [47:0] K_NEW    = 48'(COEF_NEW);
  localparam logic signed [47:0] K_OLD    = 48'(COEF_OLD);
  localparam logic [34:0]        K_USEC   = 35'(USEC_SCALE);

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [48:0] hi;
    logic signed [48:0] lo;
    hi = 49'sh0_7FFF_FFFF;
    lo = -49'sh0_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // Kept across samples
  logic [31:0]        prev_time;
  logic [15:0]        prev_abs;
  logic signed [31:0] accel;
  logic signed [31:0] torque_f;
  logic [15:0]        still_cnt;
  logic               mode_reg;

  // Per-sample working registers
  logic [15:0]        abs_rate;
  logic               d_neg;
  logic [15:0]        d_mag;
  logic [31:0]        dt;
  logic [34:0]        quo;
  logic [31:0]        rem;
  logic [5:0]         div_cnt;
  logic signed [31:0] raw;
  logic signed [47:0] p_new;
  logic signed [47:0] p_old;

  // Accept-cycle arithmetic
  logic [15:0] abs_in;
  logic [16:0] d_in;
  logic [16:0] d_abs;

  assign abs_in = rate_sample[15] ? (16'(~rate_sample) + 16'd1) : 16'(rate_sample);
  assign d_in   = {1'b0, abs_in} - {1'b0, prev_abs};
  assign d_abs  = d_in[16] ? (~d_in + 17'd1) : d_in;

  // Divide step
  logic [32:0] shifted;
  logic [33:0] trial;

  assign shifted = {rem, quo[DIV_BITS-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dt};

  // Torque scale and filter
  logic signed [40:0] scale_prod;
  logic signed [40:0] scale_shr;
  logic signed [48:0] filt_sum;
  logic signed [48:0] filt_shr;
  logic signed [31:0] torque_next;

  assign scale_prod  = 41'(accel) * K_TORQUE + 41'sd4;
  assign scale_shr   = scale_prod >>> 3;
  assign filt_sum    = 49'(p_new) + 49'(p_old) + 49'(ROUND_Q15);
  assign filt_shr    = filt_sum >>> 15;
  assign torque_next = sat32(filt_shr);

  // Stillness counter
  logic        moving;
  logic [15:0] cnt_inc;
  logic [15:0] cnt_base;
  logic        sleep_on;
  logic [15:0] cnt_next;

  always_comb begin
    moving   = abs_rate > cfg.airborne_threshold;
    cnt_inc  = still_cnt + 16'd1;
    cnt_base = (cnt_inc > cfg.stationary_reset) ? 16'd0 : cnt_inc;
    sleep_on = 1'b0;
    cnt_next = cnt_inc;
    if (moving) begin
      cnt_next = 16'd0;
    end else if (cnt_inc > cfg.sleep_threshold) begin
      cnt_next = cnt_base + 16'(SLEEP_JUMP);
      sleep_on = 1'b1;
    end
  end

  // Latch sample, advance history
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time <= 32'd0;
      prev_abs  <= 16'd0;
    end else if (cmd.load) begin
      prev_time <= time_us;
      prev_abs  <= abs_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      abs_rate <= abs_in;
      d_neg    <= d_in[16];
      d_mag    <= d_abs[15:0];
      dt       <= time_us - prev_time;
    end
  end

  // Bit-serial restoring divide of |d| * 1e6 by dt
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      quo     <= {19'd0, d_mag} * K_USEC;
      rem     <= 32'd0;
      div_cnt <= 6'd0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 6'd1;
      if (!trial[33]) begin
        rem <= trial[31:0];
        quo <= {quo[DIV_BITS-2:0], 1'b1};
      end else begin
        rem <= shifted[31:0];
        quo <= {quo[DIV_BITS-2:0], 1'b0};
      end
    end
  end

  // Signed, saturated rate of change; held when dt is zero
  always_ff @(posedge clk) begin
    if (rst) begin
      accel <= 32'sd0;
    end else if (cmd.accel_ld) begin
      if (!d_neg) begin
        accel <= (quo > 35'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : quo[31:0];
      end else begin
        accel <= (quo > 35'h0_8000_0000) ? 32'sh8000_0000 : (~quo[31:0] + 32'd1);
      end
    end
  end

  // Torque products
  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      raw <= sat32(49'(scale_shr));
    end
    if (cmd.mnew) begin
      p_new <= 48'(raw) * K_NEW;
    end
    if (cmd.mold) begin
      p_old <= 48'(torque_f) * K_OLD;
    end
  end

  // Commit state at the final step
  always_ff @(posedge clk) begin
    if (rst) begin
      torque_f  <= 32'sd0;
      still_cnt <= 16'd0;
      mode_reg  <= 1'b0;
    end else if (cmd.fin) begin
      torque_f  <= torque_next;
      still_cnt <= cnt_next;
      if (!sleep_on) begin
        mode_reg <= moving;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      torque_est   <= torque_next;
      is_moving    <= moving;
      sleep_active <= sleep_on;
      motion_mode  <= sleep_on ? mode_reg : moving;
      still_count  <= cnt_next;
    end
  end

  assign stat.dt_zero  = (dt == 32'd0);
  assign stat.div_done = (div_cnt == 6'(DIV_BITS - 1));
  assign stat.out_free = !out_valid || !out_stall;

  // Partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> rem < dt)
    else $error("divider remainder out of range");

  // A moving word clears the counter and never raises sleep
  a_moving_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_moving |-> still_count == 16'd0 && !sleep_active)
    else $error("moving word with counter or sleep set");

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the spin motion and sleep detector.
// Gyro samples go in with random gaps and result words are taken with random
// stalls. Every word is checked, all but the first three against a behavioral
// model of the rate divide, the torque filter and the motion and sleep logic.
// The run steps through several threshold settings, including the extremes.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import smsd_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 12;
  localparam int MAX_GAP        = 16;
  localparam int PHASE_SAMPLES  = 275;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 60;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int SHOWN_ERRORS   = 10;
  localparam bit MODE_STATIONARY = 1'b0;

  typedef struct packed {
    logic signed [31:0] torque;
    logic               moving;
    logic               sleep;
    logic               mode;
    logic [15:0]        count;
  } motion_word_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [1:0]         reg_idx;
    logic [15:0]        reg_val;
    logic signed [15:0] rate;
    logic [31:0]        stamp;
    bit                 typed;
    motion_word_t       want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] rate_sample = '0;
  logic [31:0]        time_us = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] torque_est;
  logic               is_moving;
  logic               sleep_active;
  logic               motion_mode;
  logic [15:0]        still_count;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Model state and threshold mirror
  logic [31:0]        last_time = '0;
  longint             last_abs_rate = 0;
  logic signed [31:0] last_accel = '0;
  logic signed [31:0] smoothed_torque = '0;
  logic [15:0]        still_ctr = '0;
  logic               mode_bit = 1'b0;
  logic [15:0]        cfg_airborne = 16'd3200;
  logic [15:0]        cfg_sleep = 16'd100;
  logic [15:0]        cfg_restart = 16'd1000;

  motion_word_t       pending_words[$];
  stim_row_t          stim_rows[$];
  int                 bad_words = 0;
  int                 words_seen = 0;
  int                 hold_left = 0;
  int unsigned        cycle_count = 0;
  bit                 gaps_on = 1'b1;
  bit                 spinning = 1'b0;
  logic [31:0]        stream_time = 32'h1000;

  spin_motion_sleep_detector uut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < longint'(32'sh80000000)) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Advance the model by one sample and return the word it must produce
  function automatic motion_word_t compute_motion_word(logic signed [15:0] rate,
                                                       logic [31:0] stamp);
    longint             abs_rate;
    longint             delta;
    longint             quot;
    longint             raw;
    logic [31:0]        dt;
    logic signed [31:0] accel;
    motion_word_t       w;
    abs_rate = (rate < 0) ? -longint'(rate) : longint'(rate);
    dt = stamp - last_time;
    // hold the rate of change when the timestamp did not move
    if (dt == 32'd0) begin
      accel = last_accel;
    end else begin
      delta = abs_rate - last_abs_rate;
      quot = (((delta < 0) ? -delta : delta) * USEC_SCALE) / longint'(dt);
      accel = clamp32((delta < 0) ? -quot : quot);
    end
    last_accel = accel;
    raw = clamp32((longint'(accel) * COEF_TORQUE + 4) >>> 3);
    smoothed_torque = clamp32((raw * COEF_NEW + longint'(smoothed_torque) * COEF_OLD
                               + ROUND_Q15) >>> 15);
    w.moving = abs_rate > longint'(cfg_airborne);
    w.sleep = 1'b0;
    // clear on motion, else count up and jump once past the sleep threshold
    if (w.moving) begin
      still_ctr = '0;
    end else begin
      still_ctr = still_ctr + 16'd1;
      if (still_ctr > cfg_sleep) begin
        if (still_ctr > cfg_restart) still_ctr = '0;
        still_ctr = still_ctr + 16'(SLEEP_JUMP);
        w.sleep = 1'b1;
      end
    end
    if (!w.sleep) mode_bit = w.moving;
    last_time = stamp;
    last_abs_rate = abs_rate;
    w.torque = smoothed_torque;
    w.mode = mode_bit;
    w.count = still_ctr;
    return w;
  endfunction

  function automatic void add_sample(logic signed [15:0] rate, logic [31:0] stamp,
                                     bit typed = 1'b0, motion_word_t want = '0);
    stim_row_t row;
    row.kind = ROW_SAMPLE;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.rate = rate;
    row.stamp = stamp;
    row.typed = typed;
    row.want = want;
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  function automatic void add_write(logic [1:0] idx, logic [15:0] value);
    stim_row_t row;
    row.kind = ROW_WRITE;
    row.reg_idx = idx;
    row.reg_val = value;
    row.rate = '0;
    row.stamp = '0;
    row.typed = 1'b0;
    row.want = '0;
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  // Offer one sample after a random gap; valid stays high once accepted
  task automatic send_sample(input logic signed [15:0] rate, input logic [31:0] stamp,
                             input bit typed, input motion_word_t want);
    int unsigned  gap;
    motion_word_t predicted;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    predicted = compute_motion_word(rate, stamp);
    pending_words.insert(pending_words.size(), typed ? want : predicted);
    in_valid <= 1'b1;
    rate_sample <= rate;
    time_us <= stamp;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and hold until every expected word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_AIRBORNE:   cfg_airborne = value;
      REG_SLEEP:      cfg_sleep = value;
      REG_STAT_RESET: cfg_restart = value;
      default: ;
    endcase
    // idle between transfers
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] airborne, input logic [15:0] sleep_at,
                            input logic [15:0] restart_at);
    wait_drained();
    write_reg(REG_AIRBORNE, airborne);
    write_reg(REG_SLEEP, sleep_at);
    write_reg(REG_STAT_RESET, restart_at);
  endtask

  // Mostly plausible gyro streams, with zero deltas, wraps and raw noise mixed in
  task automatic random_phase(input int count);
    int unsigned pick;
    int unsigned lo;
    int          mag;
    logic signed [15:0] rate;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 49) == 0) wait_drained();
      pick = $urandom_range(0, 99);
      rate = 16'($urandom);
      if (pick < 70) begin
        if ($urandom_range(0, 19) == 0) spinning = !spinning;
        stream_time = stream_time + $urandom_range(200, 3000);
        if (spinning) begin
          lo = (cfg_airborne >= 16'd32768) ? 32768 : cfg_airborne + 1;
          mag = $urandom_range(lo, 32768);
        end else begin
          mag = $urandom_range(0, (cfg_airborne > 16'd32768) ? 32768 : cfg_airborne);
        end
        if ($urandom_range(0, 1) == 1) mag = -mag;
        if (mag > 32767) mag = -32768;
        rate = 16'(mag);
      end else if (pick < 86 && pick >= 80) begin
        stream_time = 32'hffff_ffff - $urandom_range(0, 2000);
      end else if (pick >= 86) begin
        stream_time = $urandom;
      end
      send_sample(rate, stream_time, 1'b0, '0);
    end
  endtask

  // Take result words with random stalls and check each one
  always @(posedge clk) begin : take_words
    motion_word_t seen;
    motion_word_t want;
    if (rst) begin
      hold_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen.torque = torque_est;
        seen.moving = is_moving;
        seen.sleep = sleep_active;
        seen.mode = motion_mode;
        seen.count = still_count;
        if (pending_words.size() == 0) begin
          bad_words++;
          if (bad_words <= SHOWN_ERRORS)
            $display("word %0d arrived with none expected: torque=%0d count=%0d",
                     words_seen, seen.torque, seen.count);
        end else begin
          want = pending_words.pop_front();
          if (seen !== want) begin
            bad_words++;
            if (bad_words <= SHOWN_ERRORS) begin
              $display("word %0d: expected torque=%0d moving=%b sleep=%b mode=%b count=%0d",
                       words_seen, want.torque, want.moving, want.sleep, want.mode,
                       want.count);
              $display("word %0d: actual   torque=%0d moving=%b sleep=%b mode=%b count=%0d",
                       words_seen, seen.torque, seen.moving, seen.sleep, seen.mode,
                       seen.count);
            end
          end
        end
        words_seen++;
        hold_left = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      end else if (hold_left != 0) begin
        hold_left--;
      end
      out_stall <= (hold_left != 0);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("spin_motion_sleep_detector: mismatch");
      $finish;
    end
  end

  initial begin
    // first samples after reset, at reset thresholds
    add_sample(16'sd0, 32'd0, 1'b1, motion_word_t'{32'sd0, 1'b0, 1'b0, MODE_STATIONARY, 16'd1});
    add_sample(16'sd0, 32'd1000, 1'b1,
               motion_word_t'{32'sd0, 1'b0, 1'b0, MODE_STATIONARY, 16'd2});
    add_sample(16'sd0, 32'd1000, 1'b1,
               motion_word_t'{32'sd0, 1'b0, 1'b0, MODE_STATIONARY, 16'd3});
    // full-scale steps, zero delta and one-microsecond deltas that saturate
    add_sample(16'sd32767, 32'd2000);
    add_sample(-16'sd32768, 32'd2000);
    add_sample(16'sd0, 32'd2001);
    add_sample(16'sd32767, 32'd2002);
    // airborne threshold boundary
    add_sample(16'sd3200, 32'd2100);
    add_sample(16'sd3201, 32'd2200);
    add_sample(-16'sd3201, 32'd2300);
    add_sample(-16'sd3200, 32'd2400);
    // huge delta, then a delta across the timestamp wrap
    add_sample(16'sd0, 32'hffff_ff00);
    add_sample(16'sd100, 32'h0000_0040);
    // low sleep limits: sleep jump, then restart past the reset limit
    add_write(REG_SLEEP, 16'd2);
    add_write(REG_STAT_RESET, 16'd5);
    for (int k = 1; k <= 6; k++) add_sample(16'sd0, 32'h100 * k);
    add_sample(16'sd5000, 32'h700);
    add_sample(16'sd0, 32'h800);
    // airborne threshold at its extremes
    add_write(REG_AIRBORNE, 16'd0);
    add_sample(16'sd1, 32'h900);
    add_sample(16'sd0, 32'ha00);
    add_write(REG_AIRBORNE, 16'd32768);
    add_sample(-16'sd32768, 32'hb00);
    add_sample(16'sd32767, 32'hc00);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk the directed table
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
      end else begin
        send_sample(stim_rows[i].rate, stim_rows[i].stamp, stim_rows[i].typed,
                    stim_rows[i].want);
      end
    end

    // random streams under several threshold settings
    set_config(16'd3200, 16'd100, 16'd1000);
    random_phase(PHASE_SAMPLES);
    set_config(16'd0, 16'd0, 16'd0);
    random_phase(PHASE_SAMPLES);
    set_config(16'd32768, 16'd65535, 16'd65535);
    random_phase(PHASE_SAMPLES);
    repeat (3) begin
      set_config(16'($urandom_range(0, 32768)), 16'($urandom_range(0, 200)),
                 16'($urandom_range(0, 400)));
      random_phase(PHASE_SAMPLES);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_words == 0) begin
      $display("spin_motion_sleep_detector: match");
    end else begin
      $display("spin_motion_sleep_detector: mismatch");
    end
    $finish;
  end

endmodule
